// File: src/assert_macros.svh
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on the rising clock, ignored while reset is applied.
`define PIDC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Concurrent assertion on the rising clock that also holds during reset.
`define PIDC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// File: src/pidc_pkg.sv
// Package with widths, register codes and arithmetic helpers of the PID controller.
`default_nettype none

package pidc_pkg;

  // Sample, gain and derived datapath widths.
  localparam int SampleW      = 16;
  localparam int GainW        = 16;
  localparam int GainFracBits = 8;
  localparam int ErrW         = SampleW + 1;
  localparam int ProdW        = ErrW + GainW + 1;
  localparam int ShW          = ProdW - GainFracBits;
  localparam int AccW         = ShW + 2;

  // Configuration port geometry.
  localparam int RegIdxW = 3;
  localparam int AddrW   = RegIdxW + 2;
  localparam int DataW   = 32;

  // Register indexes on the configuration port.
  typedef enum logic [RegIdxW-1:0] {
    REG_PROP_GAIN        = 3'd0,
    REG_INTEGRAL_GAIN    = 3'd1,
    REG_DERIV_GAIN       = 3'd2,
    REG_OUT_LOW          = 3'd3,
    REG_OUT_HIGH         = 3'd4,
    REG_INCREMENTAL_MODE = 3'd5,
    REG_REVERSE_ACTION   = 3'd6
  } reg_idx_e;

  // Result of a saturating clamp.
  typedef struct packed {
    logic signed [SampleW-1:0] value;
    logic                      hit;
  } clamp_t;

  // Clamp to [lo, hi]; the upper limit is tested first.
  function automatic clamp_t sat_clamp(input logic signed [AccW-1:0]    v,
                                       input logic signed [SampleW-1:0] lo,
                                       input logic signed [SampleW-1:0] hi);
    clamp_t r;
    if (v > AccW'(hi)) begin
      r.value = hi;
      r.hit   = 1'b1;
    end else if (v < AccW'(lo)) begin
      r.value = lo;
      r.hit   = 1'b1;
    end else begin
      r.value = SampleW'(v);
      r.hit   = 1'b0;
    end
    return r;
  endfunction

  // Signed gain times operand, scaled down with rounding toward minus infinity.
  function automatic logic signed [ShW-1:0] gain_mul(input logic [GainW-1:0]      gain,
                                                    input logic                  neg,
                                                    input logic signed [ErrW-1:0] operand);
    logic signed [GainW:0]   g;
    logic signed [ProdW-1:0] prod;
    g = signed'({1'b0, gain});
    if (neg) begin
      g = -g;
    end
    prod = ProdW'(g) * ProdW'(operand);
    return ShW'(prod >>> GainFracBits);
  endfunction

endpackage

`default_nettype wire

// File: src/pid_controller_step.sv
// Top level of the fixed-point PID controller: input register, step logic, state and register port.
`default_nettype none

// The controller takes one item per cycle while no result waits on out_ready_i, and returns one result per item.
// An accepted item is held in the input register together with its error and
// its measurement change. While the item is held there, the three gain
// products, the saturated integral and the saturated drive are formed by
// combinational logic, and the result register and the controller state
// take them when the result register moves on. The result is shown from
// the result register, and items can follow back to back. in_ready_o drops
// only while the input register holds an item and a finished result waits
// on out_ready_i. Registers are written through the APB-style port at byte
// address 4*index. A write of either limit clamps the stored integral and
// drive to the new pair at once. Registers should be written only while no
// item is in flight.
module pid_controller_step (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                command_i,
  input  logic signed [pidc_pkg::SampleW-1:0] setpoint_i,
  input  logic signed [pidc_pkg::SampleW-1:0] measurement_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [pidc_pkg::SampleW-1:0] drive_o,
  output logic                                at_limit_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [pidc_pkg::AddrW-1:0]          paddr,
  input  logic [pidc_pkg::DataW-1:0]          pwdata,
  output logic [pidc_pkg::DataW-1:0]          prdata,
  output logic                                pready
);
  import pidc_pkg::*;

  // Configuration registers.
  logic [GainW-1:0]          prop_gain_q, integral_gain_q, deriv_gain_q;
  logic signed [SampleW-1:0] out_low_q, out_high_q;
  logic signed [SampleW-1:0] out_low_d, out_high_d;
  logic                      incremental_q, reverse_q;

  // Controller state.
  logic signed [SampleW-1:0] integral_q, integral_d;
  logic signed [SampleW-1:0] last_drive_q, last_drive_d;
  logic signed [SampleW-1:0] prev_meas_q;

  // Input and result registers.
  logic                      s1_valid_q, out_valid_q;
  logic                      s1_cmd_q;
  logic signed [ErrW-1:0]    s1_err_q, s1_dmeas_q;
  logic signed [SampleW-1:0] drive_q;
  logic                      at_limit_q;

  logic     advance;
  logic     cfg_wr;
  reg_idx_e cfg_idx;

  // Step logic terms.
  logic signed [ShW-1:0]  p_term, i_term, d_term;
  logic signed [AccW-1:0] i_acc, drv_acc, last_term;
  clamp_t                 i_cl, drv_cl, cfg_i_cl, cfg_d_cl;

  // The result register moves unless its result is held at the output, and
  // the input register takes a new item whenever it is empty or moves on.
  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || advance;

  // Register port decode.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_e'(paddr[AddrW-1:2]);

  // Read data mux.
  always_comb begin
    prdata = '0;
    case (cfg_idx)
      REG_PROP_GAIN:        prdata = DataW'(prop_gain_q);
      REG_INTEGRAL_GAIN:    prdata = DataW'(integral_gain_q);
      REG_DERIV_GAIN:       prdata = DataW'(deriv_gain_q);
      REG_OUT_LOW:          prdata = DataW'(out_low_q);
      REG_OUT_HIGH:         prdata = DataW'(out_high_q);
      REG_INCREMENTAL_MODE: prdata = DataW'(incremental_q);
      REG_REVERSE_ACTION:   prdata = DataW'(reverse_q);
      default:              prdata = '0;
    endcase
  end

  // New limit pair as it stands after this cycle's write.
  always_comb begin
    out_low_d  = out_low_q;
    out_high_d = out_high_q;
    if (cfg_wr && cfg_idx == REG_OUT_LOW) begin
      out_low_d = signed'(pwdata[SampleW-1:0]);
    end
    if (cfg_wr && cfg_idx == REG_OUT_HIGH) begin
      out_high_d = signed'(pwdata[SampleW-1:0]);
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_q     <= GainW'(256);
      integral_gain_q <= '0;
      deriv_gain_q    <= '0;
      out_low_q       <= {1'b1, {(SampleW-1){1'b0}}};
      out_high_q      <= {1'b0, {(SampleW-1){1'b1}}};
      incremental_q   <= 1'b0;
      reverse_q       <= 1'b0;
    end else begin
      out_low_q  <= out_low_d;
      out_high_q <= out_high_d;
      if (cfg_wr) begin
        case (cfg_idx)
          REG_PROP_GAIN:        prop_gain_q     <= pwdata[GainW-1:0];
          REG_INTEGRAL_GAIN:    integral_gain_q <= pwdata[GainW-1:0];
          REG_DERIV_GAIN:       deriv_gain_q    <= pwdata[GainW-1:0];
          REG_INCREMENTAL_MODE: incremental_q   <= pwdata[0];
          REG_REVERSE_ACTION:   reverse_q       <= pwdata[0];
          default:              ;
        endcase
      end
    end
  end

  // Input register: error and measurement change; the last measurement follows
  // every accepted step item and is left alone by a clear.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      prev_meas_q <= '0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
      if (in_valid_i && !command_i) begin
        prev_meas_q <= measurement_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_cmd_q   <= command_i;
      s1_err_q   <= ErrW'(setpoint_i) - ErrW'(measurement_i);
      s1_dmeas_q <= ErrW'(measurement_i) - ErrW'(prev_meas_q);
    end
  end

  // Step logic: gain products, saturating integral and drive.
  always_comb begin
    p_term    = gain_mul(prop_gain_q, reverse_q, s1_err_q);
    i_term    = gain_mul(integral_gain_q, reverse_q, s1_err_q);
    d_term    = gain_mul(deriv_gain_q, reverse_q, s1_dmeas_q);
    i_acc     = AccW'(integral_q) + AccW'(i_term);
    i_cl      = sat_clamp(i_acc, out_low_q, out_high_q);
    last_term = incremental_q ? AccW'(last_drive_q) : AccW'(0);
    drv_acc   = AccW'(p_term) + AccW'(i_cl.value) - AccW'(d_term) + last_term;
    drv_cl    = sat_clamp(drv_acc, out_low_q, out_high_q);
  end

  // State update: a limit write clamps the state, a step or a clear rewrites it.
  always_comb begin
    cfg_i_cl     = sat_clamp(AccW'(integral_q), out_low_d, out_high_d);
    cfg_d_cl     = sat_clamp(AccW'(last_drive_q), out_low_d, out_high_d);
    integral_d   = integral_q;
    last_drive_d = last_drive_q;
    if (cfg_wr && (cfg_idx == REG_OUT_LOW || cfg_idx == REG_OUT_HIGH)) begin
      integral_d   = cfg_i_cl.value;
      last_drive_d = cfg_d_cl.value;
    end else if (advance && s1_valid_q) begin
      if (s1_cmd_q) begin
        integral_d   = '0;
        last_drive_d = '0;
      end else begin
        integral_d   = i_cl.value;
        last_drive_d = drv_cl.value;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integral_q   <= '0;
      last_drive_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      integral_q   <= integral_d;
      last_drive_q <= last_drive_d;
      if (advance) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (advance && s1_valid_q) begin
      drive_q    <= s1_cmd_q ? '0 : drv_cl.value;
      at_limit_q <= s1_cmd_q ? 1'b0 : drv_cl.hit;
    end
  end

  assign out_valid_o = out_valid_q;
  assign drive_o     = drive_q;
  assign at_limit_o  = at_limit_q;

endmodule

`default_nettype wire

// File: src/pidc_checker.sv
// Port-level checker for the PID controller and its bind to the top level.
`default_nettype none
`include "assert_macros.svh"

module pidc_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_ready_o,
  input  logic                                out_valid_o,
  input  logic                                out_ready_i,
  input  logic signed [pidc_pkg::SampleW-1:0] drive_o,
  input  logic                                at_limit_o,
  input  logic                                pready
);

  // A result that is not taken stays with the same value.
  `PIDC_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(drive_o) && $stable(at_limit_o), "result changed while stalled")

  // Input is refused only while a result waits at the output.
  `PIDC_ASSERT(a_ready_stall, !in_ready_o |-> out_valid_o && !out_ready_i, "input stalled without output backpressure")

  // An empty output lets the input side through.
  `PIDC_ASSERT(a_ready_free, !out_valid_o |-> in_ready_o, "input stalled with empty output")

  // No result is shown during reset, and the register port never waits.
  `PIDC_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> !out_valid_o && pready, "bad port state in reset")

endmodule

bind pid_controller_step pidc_checker u_pidc_checker (.*);

`default_nettype wire

// File: bench/testbench.sv
// Self-checking testbench for the PID controller step block with a built-in drive predictor.
module testbench;
  import pidc_pkg::*;

  // Item commands and the register index that no register answers to.
  localparam logic                CMD_STEP   = 1'b0;
  localparam logic                CMD_CLEAR  = 1'b1;
  localparam logic [RegIdxW-1:0]  REG_UNUSED = 3'd7;
  localparam int                  ITEMS_PER_PHASE = 125;
  localparam int                  RANDOM_PHASES   = 14;
  localparam int                  STALL_LIMIT     = 4000;

  typedef struct {
    logic                      cmd;
    logic signed [SampleW-1:0] setpoint;
    logic signed [SampleW-1:0] measurement;
  } sample_t;

  typedef struct {
    logic signed [SampleW-1:0] drive;
    logic                      at_limit;
  } drive_result_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b1;
  logic                      in_valid_i = 1'b0;
  logic                      in_ready_o;
  logic                      command_i = CMD_STEP;
  logic signed [SampleW-1:0] setpoint_i = '0;
  logic signed [SampleW-1:0] measurement_i = '0;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  logic signed [SampleW-1:0] drive_o;
  logic                      at_limit_o;
  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [AddrW-1:0]          paddr = '0;
  logic [DataW-1:0]          pwdata = '0;
  logic [DataW-1:0]          prdata;
  logic                      pready;

  // Controller registers and state as the predictor tracks them.
  logic [GainW-1:0] cfg_kp = 16'd256;
  logic [GainW-1:0] cfg_ki = '0;
  logic [GainW-1:0] cfg_kd = '0;
  longint           cfg_low = -32768;
  longint           cfg_high = 32767;
  bit               cfg_incremental = 1'b0;
  bit               cfg_reverse = 1'b0;
  longint           integ_term = 0;
  longint           held_drive = 0;
  longint           held_measurement = 0;

  sample_t          pending_samples[$];
  drive_result_t    expected_drives[$];
  int unsigned      items_issued = 0;
  int unsigned      items_accepted = 0;
  int unsigned      mismatches = 0;
  int unsigned      stall_cycles = 0;
  bit               calm = 1'b0;
  logic signed [SampleW-1:0] target_sp = '0;

  pid_controller_step dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .command_i    (command_i),
    .setpoint_i   (setpoint_i),
    .measurement_i(measurement_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .drive_o      (drive_o),
    .at_limit_o   (at_limit_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Upper limit is tested first, so crossed limits resolve to the upper one.
  function automatic longint clamp_to_limits(input longint v, output bit hit);
    hit = 1'b1;
    if (v > cfg_high) return cfg_high;
    if (v < cfg_low) return cfg_low;
    hit = 1'b0;
    return v;
  endfunction

  // Gain times operand, floored back to integer scale.
  function automatic longint scale_by_gain(input logic [GainW-1:0] gain, input longint operand);
    longint g;
    g = gain;
    if (cfg_reverse) g = -g;
    return (g * operand) >>> GainFracBits;
  endfunction

  // A limit write pulls the stored integral and drive inside the new pair at once.
  function automatic void apply_register(input logic [RegIdxW-1:0] idx,
                                         input logic [DataW-1:0] data);
    bit hit;
    case (idx)
      REG_PROP_GAIN:        cfg_kp = data[GainW-1:0];
      REG_INTEGRAL_GAIN:    cfg_ki = data[GainW-1:0];
      REG_DERIV_GAIN:       cfg_kd = data[GainW-1:0];
      REG_OUT_LOW, REG_OUT_HIGH: begin
        if (idx == REG_OUT_LOW) cfg_low = longint'(signed'(data[SampleW-1:0]));
        else cfg_high = longint'(signed'(data[SampleW-1:0]));
        integ_term = clamp_to_limits(integ_term, hit);
        held_drive = clamp_to_limits(held_drive, hit);
      end
      REG_INCREMENTAL_MODE: cfg_incremental = data[0];
      REG_REVERSE_ACTION:   cfg_reverse = data[0];
      default: ;
    endcase
  endfunction

  // One control step; the derivative acts on the measurement change.
  function automatic drive_result_t predict_drive(input sample_t s);
    drive_result_t r;
    longint err, p, d, sum;
    bit hit;
    r.drive = '0;
    r.at_limit = 1'b0;
    if (s.cmd == CMD_CLEAR) begin
      integ_term = 0;
      held_drive = 0;
      return r;
    end
    err = longint'(s.setpoint) - longint'(s.measurement);
    integ_term = clamp_to_limits(integ_term + scale_by_gain(cfg_ki, err), hit);
    p = scale_by_gain(cfg_kp, err);
    d = scale_by_gain(cfg_kd, longint'(s.measurement) - held_measurement);
    sum = p + integ_term - d;
    if (cfg_incremental) sum += held_drive;
    held_drive = clamp_to_limits(sum, hit);
    held_measurement = longint'(s.measurement);
    r.drive = SampleW'(held_drive);
    r.at_limit = hit;
    return r;
  endfunction

  // Setup cycle, then access cycle; the register takes the value at the access edge.
  task automatic apb_write(input logic [RegIdxW-1:0] idx, input logic [DataW-1:0] data);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    apply_register(idx, data);
  endtask

  // Upper bits of the data word carry noise that the register must ignore.
  task automatic write_reg(input logic [RegIdxW-1:0] idx, input logic [15:0] v);
    apb_write(idx, {16'($urandom()), v});
  endtask

  task automatic queue_sample(input logic cmd, input logic signed [SampleW-1:0] sp,
                              input logic signed [SampleW-1:0] meas);
    sample_t s;
    s.cmd = cmd;
    s.setpoint = sp;
    s.measurement = meas;
    pending_samples.push_back(s);
    items_issued++;
  endtask

  function automatic logic signed [SampleW-1:0] pick_extreme();
    case ($urandom_range(6))
      0: return -16'sd32768;
      1: return -16'sd32767;
      2: return -16'sd1;
      3: return 16'sd0;
      4: return 16'sd1;
      5: return 16'sd32766;
      default: return 16'sd32767;
    endcase
  endfunction

  // Mostly a slowly moving loop around a target, the rest noise and extremes.
  task automatic queue_random_sample();
    logic                      cmd;
    logic signed [SampleW-1:0] sp, meas;
    cmd = ($urandom_range(99) < 6) ? CMD_CLEAR : CMD_STEP;
    case ($urandom_range(9))
      0, 1, 2: begin
        sp = SampleW'($urandom());
        meas = SampleW'($urandom());
      end
      3: begin
        sp = pick_extreme();
        meas = pick_extreme();
      end
      default: begin
        if ($urandom_range(9) == 0) target_sp = SampleW'(int'($urandom_range(4000)) - 2000);
        sp = target_sp;
        meas = SampleW'(int'(target_sp) + int'($urandom_range(400)) - 200);
      end
    endcase
    queue_sample(cmd, sp, meas);
  endtask

  function automatic logic [GainW-1:0] rand_gain();
    case ($urandom_range(7))
      0: return 16'hFFFF;
      1: return 16'h0000;
      2, 3: return GainW'($urandom());
      default: return GainW'($urandom_range(768));
    endcase
  endfunction

  // Limits are mostly ordered, sometimes full range, sometimes crossed.
  task automatic write_random_limits();
    logic signed [SampleW-1:0] lo, hi, t;
    lo = SampleW'($urandom());
    hi = SampleW'($urandom());
    case ($urandom_range(9))
      0, 1: begin
        lo = -16'sd32768;
        hi = 16'sd32767;
      end
      2: if (lo < hi) begin
        t = lo;
        lo = hi;
        hi = t;
      end
      default: if (lo > hi) begin
        t = lo;
        lo = hi;
        hi = t;
      end
    endcase
    if ($urandom_range(1)) begin
      write_reg(REG_OUT_LOW, lo);
      write_reg(REG_OUT_HIGH, hi);
    end else begin
      write_reg(REG_OUT_HIGH, hi);
      write_reg(REG_OUT_LOW, lo);
    end
  endtask

  task automatic set_phase_config(input int phase);
    logic signed [SampleW-1:0] lim;
    case (phase)
      1: begin
        write_reg(REG_PROP_GAIN, 16'hFFFF);
        write_reg(REG_INTEGRAL_GAIN, 16'hFFFF);
        write_reg(REG_DERIV_GAIN, 16'hFFFF);
        write_reg(REG_OUT_LOW, 16'h8000);
        write_reg(REG_OUT_HIGH, 16'h7FFF);
        write_reg(REG_INCREMENTAL_MODE, {15'($urandom()), 1'b1});
        write_reg(REG_REVERSE_ACTION, {15'($urandom()), 1'b1});
      end
      2: begin
        write_reg(REG_PROP_GAIN, 16'h0000);
        write_reg(REG_INTEGRAL_GAIN, 16'h0000);
        write_reg(REG_DERIV_GAIN, 16'h0000);
        write_reg(REG_INCREMENTAL_MODE, {15'($urandom()), 1'b0});
        write_reg(REG_REVERSE_ACTION, {15'($urandom()), 1'b0});
      end
      3: begin
        lim = SampleW'($urandom());
        write_reg(REG_OUT_LOW, lim);
        write_reg(REG_OUT_HIGH, lim);
        write_reg(REG_PROP_GAIN, rand_gain());
        write_reg(REG_INTEGRAL_GAIN, rand_gain());
      end
      default: begin
        if (phase == 0 || $urandom_range(9) < 6) write_reg(REG_PROP_GAIN, rand_gain());
        if (phase == 0 || $urandom_range(9) < 6) write_reg(REG_INTEGRAL_GAIN, rand_gain());
        if (phase == 0 || $urandom_range(9) < 6) write_reg(REG_DERIV_GAIN, rand_gain());
        if (phase == 0 || $urandom_range(9) < 6) write_random_limits();
        if (phase == 0 || $urandom_range(9) < 6)
          write_reg(REG_INCREMENTAL_MODE, 16'($urandom()));
        if (phase == 0 || $urandom_range(9) < 6)
          write_reg(REG_REVERSE_ACTION, 16'($urandom()));
      end
    endcase
  endtask

  // Every result comes back before the controller is considered idle.
  task automatic wait_drained();
    while (items_accepted != items_issued || expected_drives.size() != 0) @(posedge clk_i);
  endtask

  // Item driver: holds an item until accepted, idles at random.
  always @(posedge clk_i) begin
    sample_t cur;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_ready_o) begin
      if (pending_samples.size() != 0 && (calm || $urandom_range(99) >= 12)) begin
        cur = pending_samples.pop_front();
        in_valid_i <= 1'b1;
        command_i <= cur.cmd;
        setpoint_i <= cur.setpoint;
        measurement_i <= cur.measurement;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result side back-pressure.
  always @(posedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(99) >= 12);
  end

  // Monitor: predicts on accepted items and checks accepted results in order.
  always @(posedge clk_i) begin
    sample_t       seen;
    drive_result_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        seen.cmd = command_i;
        seen.setpoint = setpoint_i;
        seen.measurement = measurement_i;
        expected_drives.push_back(predict_drive(seen));
        items_accepted++;
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_drives.size() == 0) begin
          $error("unexpected result: drive %0d, at_limit %0b", drive_o, at_limit_o);
          mismatches++;
        end else begin
          want = expected_drives.pop_front();
          if (drive_o !== want.drive) begin
            $error("drive: expected %0d, actual %0d", want.drive, drive_o);
            mismatches++;
          end
          if (at_limit_o !== want.at_limit) begin
            $error("at_limit: expected %0b, actual %0b", want.at_limit, at_limit_o);
            mismatches++;
          end
        end
      end
    end
  end

  // Watchdog on cycles in which no item, result or register write moves.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (psel && penable && pwrite && pready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    // The falling reset edge comes after every process waits on its events.
    rst_ni <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: unit proportional gain, full limits, extremes and a clear.
    queue_sample(CMD_STEP, 16'sd0, 16'sd0);
    queue_sample(CMD_STEP, 16'sd32767, -16'sd32768);
    queue_sample(CMD_STEP, -16'sd32768, 16'sd32767);
    queue_sample(CMD_STEP, 16'sd100, -16'sd100);
    queue_sample(CMD_CLEAR, 16'sd32767, -16'sd32768);
    wait_drained();

    // A loop settling toward a target, then measurement jumps for the derivative.
    write_reg(REG_PROP_GAIN, 16'd384);
    write_reg(REG_INTEGRAL_GAIN, 16'd64);
    write_reg(REG_DERIV_GAIN, 16'd512);
    write_reg(REG_OUT_LOW, 16'(-1000));
    write_reg(REG_OUT_HIGH, 16'd1000);
    queue_sample(CMD_STEP, 16'sd500, 16'sd0);
    queue_sample(CMD_STEP, 16'sd500, 16'sd100);
    queue_sample(CMD_STEP, 16'sd500, 16'sd250);
    queue_sample(CMD_STEP, 16'sd500, 16'sd400);
    queue_sample(CMD_STEP, 16'sd500, 16'sd600);
    queue_sample(CMD_STEP, 16'sd0, -16'sd32768);
    queue_sample(CMD_STEP, 16'sd0, 16'sd32767);
    queue_sample(CMD_CLEAR, 16'sd0, 16'sd0);
    wait_drained();

    // Incremental drive with reverse action.
    write_reg(REG_INCREMENTAL_MODE, 16'd1);
    write_reg(REG_REVERSE_ACTION, 16'd1);
    queue_sample(CMD_STEP, 16'sd300, 16'sd0);
    queue_sample(CMD_STEP, 16'sd300, 16'sd50);
    queue_sample(CMD_STEP, -16'sd300, 16'sd0);
    wait_drained();

    // Crossed limits, a clear that leaves zero outside them, a write to no register.
    write_reg(REG_OUT_LOW, 16'd100);
    write_reg(REG_OUT_HIGH, 16'(-100));
    apb_write(REG_UNUSED, 32'hFFFF_FFFF);
    queue_sample(CMD_STEP, 16'sd0, 16'sd0);
    queue_sample(CMD_STEP, 16'sd32767, -16'sd32768);
    queue_sample(CMD_CLEAR, -16'sd1, 16'sd1);
    wait_drained();

    // Random phases, each under its own register settings.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      set_phase_config(phase);
      calm = (phase == 4);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) queue_random_sample();
      wait_drained();
    end
    calm = 1'b0;

    repeat (12) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+src
src/pidc_pkg.sv
src/pid_controller_step.sv
src/pidc_checker.sv
bench/testbench.sv
